[design/etc1_pkg.sv]
// ============================================================================
// ETC1 decoder package
// Shared types, constants and small decode helpers for the ETC1 block decoder.
// ============================================================================
`default_nettype none

package etc1_pkg;

  // Width constants of the fixed request and result fields.
  localparam int BlockW = 64;
  localparam int WidthW = 14;
  localparam int CoordW = 13;
  localparam int ChanW  = 8;

  // Reset value of the image width register.
  localparam logic [WidthW-1:0] WidthReset = 14'd256;

  // Depth of the queue between the front and the back part (a power of two).
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // Index of the last pixel of a block.
  localparam logic [3:0] LastPixel = 4'd15;

  // Input request: one compressed block plus its end-of-image marker.
  typedef struct packed {
    logic [BlockW-1:0] block_word;
    logic              last_block;
  } etc1_in_t;

  // Output result: one decoded pixel.
  typedef struct packed {
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
    logic [ChanW-1:0]  red;
    logic [ChanW-1:0]  green;
    logic [ChanW-1:0]  blue;
    logic              end_of_block;
    logic              end_of_image;
  } etc1_out_t;

  // One 8-bit base color.
  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
  } etc1_rgb_t;

  // Decoded block as it waits in the queue for the back part.
  typedef struct packed {
    etc1_rgb_t         base0;
    etc1_rgb_t         base1;
    logic [2:0]        cw0;
    logic [2:0]        cw1;
    logic              flip;
    logic [15:0]       idx_lo;
    logic [15:0]       idx_hi;
    logic [CoordW-1:0] x_base;
    logic [CoordW-1:0] y_base;
    logic              last;
  } etc1_desc_t;

  // A decoded block together with its valid flag.
  typedef struct packed {
    logic       valid;
    etc1_desc_t desc;
  } etc1_entry_t;

  // Replicate a 4-bit color to 8 bits.
  function automatic logic [ChanW-1:0] expand4(input logic [3:0] v);
    return {v, v};
  endfunction

  // Replicate a 5-bit color to 8 bits.
  function automatic logic [ChanW-1:0] expand5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  // Base plus signed 3-bit delta, wrapped to 5 bits.
  function automatic logic [4:0] add_delta(input logic [4:0] v, input logic [2:0] d);
    return v + {{2{d[2]}}, d};
  endfunction

  // Intensity modifier for a table codeword and a 2-bit pixel index.
  function automatic logic signed [8:0] mod_lookup(input logic [2:0] cw,
                                                   input logic [1:0] idx);
    logic [7:0] small_mag;
    logic [7:0] big_mag;
    logic [8:0] mag;
    small_mag = 8'd0;
    big_mag   = 8'd0;
    case (cw)
      3'd0: begin small_mag = 8'd2;  big_mag = 8'd8;   end
      3'd1: begin small_mag = 8'd5;  big_mag = 8'd17;  end
      3'd2: begin small_mag = 8'd9;  big_mag = 8'd29;  end
      3'd3: begin small_mag = 8'd13; big_mag = 8'd42;  end
      3'd4: begin small_mag = 8'd18; big_mag = 8'd60;  end
      3'd5: begin small_mag = 8'd24; big_mag = 8'd80;  end
      3'd6: begin small_mag = 8'd33; big_mag = 8'd106; end
      3'd7: begin small_mag = 8'd47; big_mag = 8'd183; end
      default: begin small_mag = 8'd0; big_mag = 8'd0; end
    endcase
    mag = idx[0] ? {1'b0, big_mag} : {1'b0, small_mag};
    return idx[1] ? -$signed(mag) : $signed(mag);
  endfunction

  // Add a modifier to a channel and clamp to 0..255.
  function automatic logic [ChanW-1:0] clamp_add(input logic [ChanW-1:0] b,
                                                 input logic signed [8:0] m);
    logic signed [9:0] sum;
    sum = $signed({2'b00, b}) + $signed({m[8], m});
    if (sum[9]) begin
      return 8'd0;
    end else if (sum[8]) begin
      return 8'd255;
    end else begin
      return sum[7:0];
    end
  endfunction

endpackage

`default_nettype wire

[design/etc1_front.sv]
// ============================================================================
// ETC1 front part
// Accepts block requests, decodes base colors and codewords, and places each
// block on the image grid with the block column and row counters.
// ============================================================================
`default_nettype none

module etc1_front #(
  parameter int MAX_WIDTH  = 8192,
  parameter int MAX_HEIGHT = 8192
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire etc1_pkg::etc1_in_t          in_data_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [etc1_pkg::WidthW-1:0] cfg_wdata_i,
  input  wire logic                        queue_full_i,
  output etc1_pkg::etc1_entry_t            push_o
);

  localparam int BprMax = MAX_WIDTH / 4;
  localparam int Rows   = MAX_HEIGHT / 4;
  localparam int ColW   = (BprMax > 1) ? $clog2(BprMax) : 1;
  localparam int RowW   = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int CmpW   = 18;
  localparam logic [CmpW-1:0] BprMaxC = CmpW'(BprMax);
  localparam logic [CmpW-1:0] RowsC   = CmpW'(Rows);

  logic [etc1_pkg::WidthW-1:0] width_q;
  logic [ColW-1:0]             col_q, col_d;
  logic [RowW-1:0]             row_q, row_d;
  logic                        accept;
  logic [CmpW-1:0]             bpr_raw, bpr, col_inc, row_inc;
  logic [ColW+14:0]            col_ext;
  logic [RowW+14:0]            row_ext;
  logic [63:0]                 blk;
  logic [4:0]                  r5, g5, b5;
  etc1_pkg::etc1_desc_t        desc;

  assign blk        = in_data_i.block_word;
  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;

  // Image width register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= etc1_pkg::WidthReset;
    end else if (cfg_we_i) begin
      width_q <= cfg_wdata_i;
    end
  end

  // Blocks per row, at least one and at most the widest row.
  always_comb begin
    bpr_raw = CmpW'(width_q[etc1_pkg::WidthW-1:2]);
    if (bpr_raw == '0) begin
      bpr = CmpW'(1);
    end else if (bpr_raw > BprMaxC) begin
      bpr = BprMaxC;
    end else begin
      bpr = bpr_raw;
    end
  end

  // Next block position; a last block sends both counters home.
  always_comb begin
    col_inc = CmpW'(col_q) + CmpW'(1);
    row_inc = CmpW'(row_q) + CmpW'(1);
    col_d   = col_q;
    row_d   = row_q;
    if (in_data_i.last_block) begin
      col_d = '0;
      row_d = '0;
    end else if (col_inc >= bpr) begin
      col_d = '0;
      row_d = (row_inc >= RowsC) ? '0 : row_inc[RowW-1:0];
    end else begin
      col_d = col_inc[ColW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Block decode: base colors in individual or differential mode.
  assign r5 = blk[63:59];
  assign g5 = blk[55:51];
  assign b5 = blk[47:43];
  assign col_ext = {13'd0, col_q, 2'b00};
  assign row_ext = {13'd0, row_q, 2'b00};

  always_comb begin
    if (blk[33]) begin
      desc.base0.r = etc1_pkg::expand5(r5);
      desc.base0.g = etc1_pkg::expand5(g5);
      desc.base0.b = etc1_pkg::expand5(b5);
      desc.base1.r = etc1_pkg::expand5(etc1_pkg::add_delta(r5, blk[58:56]));
      desc.base1.g = etc1_pkg::expand5(etc1_pkg::add_delta(g5, blk[50:48]));
      desc.base1.b = etc1_pkg::expand5(etc1_pkg::add_delta(b5, blk[42:40]));
    end else begin
      desc.base0.r = etc1_pkg::expand4(blk[63:60]);
      desc.base1.r = etc1_pkg::expand4(blk[59:56]);
      desc.base0.g = etc1_pkg::expand4(blk[55:52]);
      desc.base1.g = etc1_pkg::expand4(blk[51:48]);
      desc.base0.b = etc1_pkg::expand4(blk[47:44]);
      desc.base1.b = etc1_pkg::expand4(blk[43:40]);
    end
    desc.cw0    = blk[39:37];
    desc.cw1    = blk[36:34];
    desc.flip   = blk[32];
    desc.idx_hi = blk[31:16];
    desc.idx_lo = blk[15:0];
    desc.x_base = col_ext[etc1_pkg::CoordW-1:0];
    desc.y_base = row_ext[etc1_pkg::CoordW-1:0];
    desc.last   = in_data_i.last_block;
  end

  assign push_o.valid = accept;
  assign push_o.desc  = desc;

endmodule

`default_nettype wire

[design/etc1_queue.sv]
// ============================================================================
// ETC1 block queue
// Short first-in first-out queue of decoded blocks between front and back.
// ============================================================================
`default_nettype none

module etc1_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire etc1_pkg::etc1_entry_t push_i,
  input  wire logic                  pop_i,
  output logic                       full_o,
  output etc1_pkg::etc1_entry_t      head_o
);

  etc1_pkg::etc1_desc_t              mem_q [etc1_pkg::QueueDepth];
  logic [etc1_pkg::QueuePtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [etc1_pkg::QueueCntW-1:0]    count_q;
  logic                              do_push, do_pop;

  assign full_o       = (count_q == etc1_pkg::QueueCntW'(etc1_pkg::QueueDepth));
  assign head_o.valid = (count_q != '0);
  assign head_o.desc  = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.desc;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[design/etc1_back.sv]
// ============================================================================
// ETC1 back part
// Steps through the sixteen pixels of the queue head, applies the modifier
// and clamp, and holds each pixel in an output register until taken.
// ============================================================================
`default_nettype none

module etc1_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire etc1_pkg::etc1_entry_t head_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output etc1_pkg::etc1_out_t        out_data_o
);

  logic [3:0]              pix_q;
  logic                    out_valid_q, out_valid_d;
  etc1_pkg::etc1_out_t     out_q, out_d;
  logic                    advance, load;
  logic                    sub, lo, hi;
  logic [2:0]              cw;
  logic signed [8:0]       modv;
  etc1_pkg::etc1_rgb_t     base;
  etc1_pkg::etc1_desc_t    d;

  assign d       = head_i.desc;
  assign advance = !out_valid_q || !out_stall_i;
  assign load    = advance && head_i.valid;
  assign pop_o   = load && (pix_q == etc1_pkg::LastPixel);

  // Pixel decode for the current index.
  always_comb begin
    sub  = d.flip ? pix_q[1] : pix_q[3];
    lo   = d.idx_lo[pix_q];
    hi   = d.idx_hi[pix_q];
    cw   = sub ? d.cw1 : d.cw0;
    base = sub ? d.base1 : d.base0;
    modv = etc1_pkg::mod_lookup(cw, {hi, lo});
    out_d.pixel_x      = d.x_base + {11'd0, pix_q[3:2]};
    out_d.pixel_y      = d.y_base + {11'd0, pix_q[1:0]};
    out_d.red          = etc1_pkg::clamp_add(base.r, modv);
    out_d.green        = etc1_pkg::clamp_add(base.g, modv);
    out_d.blue         = etc1_pkg::clamp_add(base.b, modv);
    out_d.end_of_block = (pix_q == etc1_pkg::LastPixel);
    out_d.end_of_image = (pix_q == etc1_pkg::LastPixel) && d.last;
  end

  // Output valid follows the head when the register may be refilled.
  always_comb begin
    if (advance) begin
      out_valid_d = head_i.valid;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Pixel counter and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (load) begin
        pix_q <= pix_q + 1'b1;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[design/etc1_block_decoder_unit.sv]
// The first pixel of a block passes through the queue and then the output register before
// it is offered, when the back part is idle. Throughput: one pixel per cycle while the output
// is not stalled, set by the back part that emits one pixel each cycle; the two-entry queue
// lets the next block be accepted while the current one is emitted. Reset: block counters go
// to zero, image width to 256 and the queue empties.
// ============================================================================
// ETC1 block decoder
// Decodes 64-bit ETC1 blocks into sixteen RGB888 pixels with image positions.
// ============================================================================
`default_nettype none

module etc1_block_decoder_unit #(
  parameter int MAX_WIDTH  = 8192,
  parameter int MAX_HEIGHT = 8192
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire etc1_pkg::etc1_in_t          in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output etc1_pkg::etc1_out_t              out_data_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [etc1_pkg::WidthW-1:0] cfg_wdata_i
);

  etc1_pkg::etc1_entry_t push, head;
  logic                  queue_full, pop;

  // Front part: request intake, block decode and grid placement.
  etc1_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .queue_full_i(queue_full),
    .push_o      (push)
  );

  // Queue of decoded blocks.
  etc1_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .pop_i (pop),
    .full_o(queue_full),
    .head_o(head)
  );

  // Back part: per-pixel modifier, clamp and output register.
  etc1_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

[design/etc1_checker.sv]
// ============================================================================
// ETC1 port checker
// Watches the result channel of the block decoder for pixel ordering and
// block framing errors.
// ============================================================================
`default_nettype none

module etc1_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire etc1_pkg::etc1_out_t out_data_o
);

  logic [3:0] seen_q;
  logic       out_take;

  assign out_take = out_valid_o && !out_stall_i;

  // Count delivered pixels modulo one block.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (out_take) begin
      seen_q <= seen_q + 1'b1;
    end
  end

  // A stalled result stays offered.
  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result valid dropped while stalled");

  // End of image only on the end of a block.
  a_eoi_on_eob: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.end_of_image |-> out_data_o.end_of_block)
    else $error("end of image without end of block");

  // Every sixteenth pixel closes a block, and no other does.
  a_eob_framing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.end_of_block == (seen_q == etc1_pkg::LastPixel)))
    else $error("end of block out of step with pixel count");

  // Pixels leave in column-major order inside the block.
  a_pixel_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.pixel_y[1:0] == seen_q[1:0]) &&
                    (out_data_o.pixel_x[1:0] == seen_q[3:2]))
    else $error("pixel position out of column-major order");

endmodule

bind etc1_block_decoder_unit etc1_checker u_checker (.*);

`default_nettype wire
